// ----- hw/rtl/stable_priority_queue_defines.svh -----
// Assertion macros shared by the checker files of the priority queue.
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/spq_pkg.sv -----
package spq_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int PRIORITY_BITS = 8;
   localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] EMPTY_HEAD_PRIORITY = 8'd100;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef logic [PRIORITY_BITS-1:0] prio_type;
   typedef logic [CNT_W-1:0]         count_type;

   typedef struct packed {
      logic        func;
      logic [7:0]  priority_req;
      logic [15:0] payload_handle;
      logic [7:0]  entry_flag;
      logic [15:0] packets_done;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  out_priority;
      logic [15:0] out_handle;
      logic [7:0]  out_flag;
      logic [15:0] out_packets;
      logic [7:0]  head_priority;
      logic [4:0]  occupancy;
   } rsp_type;

   // One stored queue entry.
   typedef struct packed {
      prio_type    prio;
      logic [15:0] handle;
      logic [7:0]  flag;
      logic [15:0] packets;
   } entry_type;

   // Per-cell control for the current cycle.
   typedef struct packed {
      logic push;
      logic pop;
      logic occupied;
   } cell_ctrl_type;

   function automatic prio_type to_stored(input logic [7:0] p);
      return PRIORITY_BITS'(p);
   endfunction

   function automatic logic [7:0] to_out(input prio_type p);
      return 8'(p);
   endfunction

endpackage

// ----- hw/rtl/spq_cell.sv -----
module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  spq_pkg::entry_type    new_entry,
   input  spq_pkg::entry_type    left_entry,
   input  logic                  left_take,
   input  spq_pkg::entry_type    right_entry,
   output spq_pkg::entry_type    entry,
   output logic                  take
);
   import spq_pkg::*;

   entry_type entry_ff, entry_in;

   // Mark this cell at or past the insertion point: free, or strictly larger.
   assign take = !ctrl.occupied || (entry_ff.prio > new_entry.prio);

   // Shift right behind an insert, load the new beat, or shift left on pop.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push) begin
         if (left_take) begin
            entry_in = left_entry;
         end else if (take) begin
            entry_in = new_entry;
         end
      end else if (ctrl.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ----- hw/rtl/stable_priority_queue.sv -----
// Stable sorted priority queue of telemetry entries.
// Request channel: present req_data and raise start; the beat is taken at
// the clock edge where start is high and busy is low. busy stays low, so
// a push or pop may be issued in every cycle.
// func selects push (insert entry) or pop (remove head). Lower priority is
// served first; equal priorities leave in arrival order.
// Response channel: one beat per request, on rsp_data with rsp_valid high
// for exactly one cycle, the cycle after the request was taken (throughput 1
// per cycle). The receiver cannot stall, so it must sample every strobe.
// The store is a row of cells, one per entry; every cell compares its
// priority with the pushed one in the same cycle and shifts right, loads
// the new entry or shifts left on pop, which sets the one-cycle rate.
// Each beat reports status, the popped entry (zero on push or error), the
// head priority after the step (100 when empty) and the occupancy.
// A push into a full queue is dropped; a pop of an empty queue reports
// an empty status. Reset empties the queue and drops any pending beat.
module stable_priority_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   count_type count_ff, count_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff, rsp_in;

   entry_type cell_entry [QUEUE_DEPTH];
   logic      cell_take  [QUEUE_DEPTH];
   entry_type new_entry;
   logic      accept, full, empty, do_push, do_pop;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == count_type'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign do_push = accept && (req_data.func == FUNC_PUSH) && !full;
   assign do_pop  = accept && (req_data.func == FUNC_POP) && !empty;

   assign new_entry.prio    = to_stored(req_data.priority_req);
   assign new_entry.handle  = req_data.payload_handle;
   assign new_entry.flag    = req_data.entry_flag;
   assign new_entry.packets = req_data.packets_done;

   // Build the chain of cells.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_ctrl_type ctrl;
      entry_type     left_entry, right_entry;
      logic          left_take;

      assign ctrl.push     = do_push;
      assign ctrl.pop      = do_pop;
      assign ctrl.occupied = (count_type'(i) < count_ff);

      if (i == 0) begin : g_first
         assign left_entry = new_entry;
         assign left_take  = 1'b0;
      end else begin : g_mid
         assign left_entry = cell_entry[i-1];
         assign left_take  = cell_take[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .left_entry  (left_entry),
         .left_take   (left_take),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .take        (cell_take[i])
      );
   end

   // Update the fill count.
   always_comb begin
      count_in = count_ff;
      if (do_push) begin
         count_in = count_ff + count_type'(1);
      end else if (do_pop) begin
         count_in = count_ff - count_type'(1);
      end
   end

   // Form the response beat.
   always_comb begin
      rsp_valid_in         = accept;
      rsp_in.status        = ST_OK;
      rsp_in.out_priority  = '0;
      rsp_in.out_handle    = '0;
      rsp_in.out_flag      = '0;
      rsp_in.out_packets   = '0;
      rsp_in.occupancy     = 5'(count_in);
      rsp_in.head_priority = empty ? EMPTY_HEAD_PRIORITY : to_out(cell_entry[0].prio);
      if (do_push) begin
         if (empty || (new_entry.prio < cell_entry[0].prio)) begin
            rsp_in.head_priority = to_out(new_entry.prio);
         end
      end else if (do_pop) begin
         rsp_in.out_priority  = to_out(cell_entry[0].prio);
         rsp_in.out_handle    = cell_entry[0].handle;
         rsp_in.out_flag      = cell_entry[0].flag;
         rsp_in.out_packets   = cell_entry[0].packets;
         rsp_in.head_priority = (count_ff > count_type'(1)) ?
                                to_out(cell_entry[1].prio) : EMPTY_HEAD_PRIORITY;
      end else if (req_data.func == FUNC_PUSH) begin
         rsp_in.status = ST_FULL;
      end else begin
         rsp_in.status = ST_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the payload without reset.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hw/rtl/spq_checker.sv -----
`include "stable_priority_queue_defines.svh"

module spq_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input spq_pkg::req_type req_data,
   input logic             rsp_valid,
   input spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   logic accept;
   assign accept = start && !busy;

   // One response beat follows every request beat, and none without one.
   `SPQ_ASSERT_NEXT(a_rsp_after_req, clock, reset, accept, rsp_valid, "missing response beat")
   `SPQ_ASSERT_NEXT(a_no_spurious, clock, reset, !accept, !rsp_valid, "response without request")

   // An empty pop leaves an empty queue with the sentinel head.
   `SPQ_ASSERT_NOW(a_empty_pop, clock, reset,
                   rsp_valid && (rsp_data.status == ST_EMPTY),
                   (rsp_data.occupancy == 5'd0) &&
                   (rsp_data.head_priority == EMPTY_HEAD_PRIORITY),
                   "empty pop with entries left")

   // A dropped push reports a full queue.
   `SPQ_ASSERT_NOW(a_full_drop, clock, reset,
                   rsp_valid && (rsp_data.status == ST_FULL),
                   rsp_data.occupancy == 5'(QUEUE_DEPTH),
                   "dropped push on a queue that is not full")

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import spq_pkg::*;

   // Longest run of cycles with no request or response beat before giving up
   localparam int QUIET_LIMIT = 400;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Shadow copy of the queue contents, head first
   entry_type   shadow_entries[$];
   // Responses worked out for accepted requests, oldest first
   rsp_type     queue_results[$];

   int unsigned error_count;
   int unsigned quiet_cycles;
   int unsigned beats_checked;
   int unsigned push_count;
   int unsigned pop_count;
   int unsigned empty_pops;
   int unsigned full_drops;
   int unsigned peak_occupancy;

   stable_priority_queue dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Apply one push or pop to the shadow queue and return the response beat
   function automatic rsp_type apply_queue_op(input req_type r);
      rsp_type   res;
      entry_type e;
      int        pos;
      res = '0;
      res.status = ST_OK;
      if (r.func == FUNC_PUSH) begin
         push_count++;
         if (shadow_entries.size() >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
            full_drops++;
         end else begin
            e.prio    = prio_type'(r.priority_req);
            e.handle  = r.payload_handle;
            e.flag    = r.entry_flag;
            e.packets = r.packets_done;
            // Insert after every held entry of lower or equal priority
            pos = 0;
            while (pos < shadow_entries.size() && shadow_entries[pos].prio <= e.prio)
               pos++;
            shadow_entries.insert(pos, e);
         end
      end else begin
         pop_count++;
         if (shadow_entries.size() == 0) begin
            res.status = ST_EMPTY;
            empty_pops++;
         end else begin
            e = shadow_entries.pop_front();
            res.out_priority = 8'(e.prio);
            res.out_handle   = e.handle;
            res.out_flag     = e.flag;
            res.out_packets  = e.packets;
         end
      end
      res.head_priority = (shadow_entries.size() > 0) ? 8'(shadow_entries[0].prio)
                                                      : EMPTY_HEAD_PRIORITY;
      res.occupancy = 5'(shadow_entries.size());
      if (shadow_entries.size() > peak_occupancy)
         peak_occupancy = shadow_entries.size();
      return res;
   endfunction

   task automatic report_mismatch(input string field_name, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
               $time, field_name, got, want);
      error_count++;
   endtask

   // Compare one response beat with the oldest outstanding result
   task automatic check_beat(input rsp_type got);
      rsp_type want;
      if (queue_results.size() == 0) begin
         report_mismatch("unexpected response beat", 32'(got.status), 32'h0);
         return;
      end
      want = queue_results.pop_front();
      beats_checked++;
      if (got.status !== want.status)
         report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.out_priority !== want.out_priority)
         report_mismatch("out_priority", 32'(got.out_priority), 32'(want.out_priority));
      if (got.out_handle !== want.out_handle)
         report_mismatch("out_handle", 32'(got.out_handle), 32'(want.out_handle));
      if (got.out_flag !== want.out_flag)
         report_mismatch("out_flag", 32'(got.out_flag), 32'(want.out_flag));
      if (got.out_packets !== want.out_packets)
         report_mismatch("out_packets", 32'(got.out_packets), 32'(want.out_packets));
      if (got.head_priority !== want.head_priority)
         report_mismatch("head_priority", 32'(got.head_priority), 32'(want.head_priority));
      if (got.occupancy !== want.occupancy)
         report_mismatch("occupancy", 32'(got.occupancy), 32'(want.occupancy));
   endtask

   // Check response beats, then log request beats taken at this edge
   always @(posedge clock) begin
      if (!reset) begin
         quiet_cycles++;
         if (rsp_valid === 1'b1) begin
            check_beat(rsp_data);
            quiet_cycles = 0;
         end
         if (start && busy === 1'b0) begin
            queue_results.push_back(apply_queue_op(req_data));
            quiet_cycles = 0;
         end
      end
   end

   // Stop a hung run
   initial begin
      while (quiet_cycles < QUIET_LIMIT)
         @(posedge clock);
      $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, queue_results.size());
      $display("Some tests failed");
      $finish;
   end

   // Present one request beat; return once it will be taken at the next edge
   task automatic send_beat(input req_type r);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      while (busy !== 1'b0)
         @(negedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // Hold off until every outstanding response has come back
   task automatic wait_for_drain();
      pause_sender(1);
      while (queue_results.size() != 0)
         @(negedge clock);
   endtask

   function automatic req_type make_push(input logic [7:0] prio, input logic [15:0] handle,
                                         input logic [7:0] flag, input logic [15:0] packets);
      req_type r;
      r.func           = FUNC_PUSH;
      r.priority_req   = prio;
      r.payload_handle = handle;
      r.entry_flag     = flag;
      r.packets_done   = packets;
      return r;
   endfunction

   // Pops carry random noise in the unused fields
   function automatic req_type make_pop();
      req_type     r;
      logic [63:0] noise;
      noise  = {$urandom, $urandom};
      r      = noise[$bits(req_type)-1:0];
      r.func = FUNC_POP;
      return r;
   endfunction

   // Priority drawn from full range, a narrow band of ties, or the range ends and 99 to 101
   function automatic logic [7:0] pick_priority(input int prio_mode);
      logic [7:0] p;
      case (prio_mode)
         0: begin
            p = 8'($urandom_range(0, 255));
         end
         1: begin
            p = 8'($urandom_range(0, 3));
         end
         default: begin
            case ($urandom_range(0, 4))
               0: p = 8'd0;
               1: p = 8'd255;
               2: p = 8'd99;
               3: p = 8'd100;
               default: p = 8'd101;
            endcase
         end
      endcase
      return p;
   endfunction

   function automatic req_type random_beat(input int push_pct, input int prio_mode);
      if ($urandom_range(0, 99) < push_pct)
         return make_push(pick_priority(prio_mode), 16'($urandom), 8'($urandom),
                          16'($urandom));
      return make_pop();
   endfunction

   // Empty pop, field extremes, ties in arrival order, then drain past empty
   task automatic test_directed();
      send_beat(make_pop());
      send_beat(make_push(8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF));
      send_beat(make_push(8'h00, 16'h0000, 8'h00, 16'h0000));
      send_beat(make_push(8'd100, 16'h1234, 8'h5A, 16'hA5C3));
      send_beat(make_push(8'd7, 16'h000A, 8'h01, 16'h0001));
      send_beat(make_push(8'd7, 16'h000B, 8'h02, 16'h0002));
      send_beat(make_push(8'd7, 16'h000C, 8'h03, 16'h0003));
      send_beat(make_push(8'hFF, 16'h0001, 8'h80, 16'h8000));
      repeat (8)
         send_beat(make_pop());
   endtask

   // Fill to the brim, push into a full queue, work at the boundary, drain
   task automatic test_full_queue();
      repeat (QUEUE_DEPTH)
         send_beat(random_beat(100, 1));
      repeat (2)
         send_beat(random_beat(100, 0));
      repeat (3) begin
         send_beat(make_pop());
         send_beat(random_beat(100, 2));
         send_beat(random_beat(100, 2));
      end
      repeat (QUEUE_DEPTH + 1)
         send_beat(make_pop());
   endtask

   // Bursts of random traffic under shifting fill, drain and balanced regimes
   task automatic test_random_traffic(input int n_items);
      int sent;
      int burst_left;
      int regime_left;
      int push_pct;
      int prio_mode;
      int max_gap;
      sent        = 0;
      burst_left  = 0;
      regime_left = 0;
      push_pct    = 50;
      prio_mode   = 0;
      max_gap     = 0;
      while (sent < n_items) begin
         if (regime_left == 0) begin
            case ($urandom_range(0, 3))
               0: push_pct = 85;
               1: push_pct = 15;
               2: push_pct = 55;
               default: push_pct = 45;
            endcase
            prio_mode   = $urandom_range(0, 2);
            max_gap     = ($urandom_range(0, 3) == 0) ? 0 : 6;
            regime_left = $urandom_range(20, 120);
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (max_gap > 0)
               pause_sender($urandom_range(1, max_gap));
         end
         send_beat(random_beat(push_pct, prio_mode));
         sent++;
         burst_left--;
         regime_left--;
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      error_count = 0;
      repeat (7)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      wait_for_drain();
      test_full_queue();
      wait_for_drain();
      test_random_traffic(750);
      wait_for_drain();
      test_random_traffic(750);

      // Let the last beats come back, then wait briefly with the sender idle
      wait_for_drain();
      repeat (4)
         @(negedge clock);

      $display("Run covered %0d pushes (%0d dropped on a full queue) and %0d pops",
               push_count, full_drops, pop_count);
      $display("(%0d on an empty queue), peak occupancy %0d, %0d beats checked",
               empty_pops, peak_occupancy, beats_checked);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
